// ===== sv/oate_pkg.sv =====
// Shared types and constants for the ordered array table engine.
package oate_pkg;

   localparam int unsigned OP_WIDTH = 3;
   localparam int unsigned INDEX_WIDTH = 7;
   localparam int unsigned OTHER_WIDTH = 6;
   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned COUNT_WIDTH = 7;
   localparam int unsigned CAPACITY = 64;
   localparam int unsigned AW = $clog2(CAPACITY);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_READ = 3'd2,
      OP_READ_LAST = 3'd3,
      OP_SWAP = 3'd4,
      OP_SORT = 3'd5,
      OP_CHECK = 3'd6,
      OP_NOP = 3'd7
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD_INDEX = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic [INDEX_WIDTH-1:0] index;
      logic [OTHER_WIDTH-1:0] other_index;
      logic signed [DATA_WIDTH-1:0] value;
      logic descending;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic signed [DATA_WIDTH-1:0] read_value;
      logic is_sorted;
      logic [COUNT_WIDTH-1:0] entry_count;
   } rsp_type;

   // Datapath commands issued by the controller.
   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_RD_A,
      CMD_RD_B,
      CMD_WR_A,
      CMD_WR_B,
      CMD_WR_VALUE,
      CMD_SET_CUR,
      CMD_DEC_CUR,
      CMD_INC_COUNT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
   } cmd_type;

endpackage

// ===== sv/oate_if.sv =====
// Valid and ready channel interface carrying one payload beat.
interface oate_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/oate_datapath.sv =====
// Entry memory, read registers and entry count of the table engine.
module oate_datapath (
   input logic clock,
   input logic reset,
   input oate_pkg::req_type req,
   input oate_pkg::cmd_type cmd,
   input logic [oate_pkg::AW-1:0] cmd_addr,
   output logic signed [oate_pkg::DATA_WIDTH-1:0] rd_a,
   output logic signed [oate_pkg::DATA_WIDTH-1:0] rd_b,
   output logic [oate_pkg::COUNT_WIDTH-1:0] count
);
   import oate_pkg::*;

   logic signed [DATA_WIDTH-1:0] mem [CAPACITY];
   logic signed [DATA_WIDTH-1:0] rd_a_ff;
   logic signed [DATA_WIDTH-1:0] rd_b_ff;
   logic [COUNT_WIDTH-1:0] count_ff;

   always_ff @(posedge clock) begin
      case (cmd.kind)
         CMD_RD_A: rd_a_ff <= mem[cmd_addr];
         CMD_RD_B: rd_b_ff <= mem[cmd_addr];
         CMD_WR_A: mem[cmd_addr] <= rd_a_ff;
         CMD_WR_B: mem[cmd_addr] <= rd_b_ff;
         CMD_WR_VALUE: mem[cmd_addr] <= req.value;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.kind == CMD_INC_COUNT) begin
         count_ff <= count_ff + COUNT_WIDTH'(1);
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;
   assign count = count_ff;
endmodule

// ===== sv/oate_ctrl.sv =====
// Controller state machine sequencing each operation over the datapath.
module oate_ctrl (
   input logic clock,
   input logic reset,
   oate_if.sink req_ch,
   oate_if.source rsp_ch,
   output oate_pkg::req_type req,
   output oate_pkg::cmd_type cmd,
   output logic [oate_pkg::AW-1:0] cmd_addr,
   input logic signed [oate_pkg::DATA_WIDTH-1:0] rd_a,
   input logic signed [oate_pkg::DATA_WIDTH-1:0] rd_b,
   input logic [oate_pkg::COUNT_WIDTH-1:0] count
);
   import oate_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR, S_READ, S_READ_DONE,
      S_SWAP_RB, S_SWAP_WA, S_SWAP_WB, S_SORT_KEY, S_SORT_RD, S_SORT_CMP,
      S_CHK_RD, S_CHK_CMP, S_CHK_EVAL, S_RESP
   } state_type;

   localparam int unsigned CW = COUNT_WIDTH;

   state_type state_ff;
   req_type req_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] k_ff;
   logic signed [DATA_WIDTH-1:0] key_ff;
   cmd_type cmd_c;
   logic [AW-1:0] addr_c;
   logic ooo;

   function automatic rsp_type status_rsp(logic [STATUS_WIDTH-1:0] status, logic sorted);
      rsp_type r;
      r = '0;
      r.status = status;
      r.is_sorted = sorted;
      return r;
   endfunction

   // Out of order when prev must come after the key (rd_b holds prev).
   assign ooo = req_ff.descending ? (rd_b < key_ff) : (key_ff < rd_b);

   assign req = req_ff;
   assign cmd = cmd_c;
   assign cmd_addr = addr_c;
   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   always_comb begin
      cmd_c = '{kind: CMD_IDLE};
      addr_c = '0;
      unique case (state_ff)
         S_SHIFT_RD: begin
            cmd_c.kind = CMD_RD_A;
            addr_c = AW'(k_ff - CW'(1));
         end
         S_SHIFT_WR: begin
            cmd_c.kind = CMD_WR_A;
            addr_c = AW'(k_ff);
         end
         S_INS_WR: begin
            cmd_c.kind = CMD_WR_VALUE;
            addr_c = AW'(k_ff);
         end
         S_READ: begin
            cmd_c.kind = CMD_RD_A;
            addr_c = AW'(i_ff);
         end
         S_SWAP_RB, S_SORT_RD: begin
            cmd_c.kind = CMD_RD_B;
            addr_c = (state_ff == S_SWAP_RB) ? AW'(k_ff) : AW'(k_ff - CW'(1));
         end
         S_SWAP_WA: begin
            cmd_c.kind = CMD_WR_A;
            addr_c = AW'(k_ff);
         end
         S_SWAP_WB: begin
            cmd_c.kind = CMD_WR_B;
            addr_c = AW'(i_ff);
         end
         S_SORT_KEY: begin
            cmd_c.kind = CMD_RD_A;
            addr_c = AW'(i_ff);
         end
         S_SORT_CMP: begin
            if (k_ff != '0 && ooo) begin
               cmd_c.kind = CMD_WR_B;
            end else begin
               cmd_c.kind = CMD_WR_A;
            end
            addr_c = AW'(k_ff);
         end
         S_CHK_RD: begin
            cmd_c.kind = CMD_RD_B;
            addr_c = AW'(i_ff - CW'(1));
         end
         S_CHK_CMP: begin
            cmd_c.kind = CMD_RD_A;
            addr_c = AW'(i_ff);
         end
         S_RESP: begin
            if (rsp_ff.status == ST_DONE &&
                  (req_ff.op == OP_INSERT || req_ff.op == OP_APPEND)) begin
               cmd_c.kind = CMD_INC_COUNT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid && req_ch.ready) begin
                  req_ff <= req_ch.payload;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               unique case (op_type'(req_ff.op))
                  OP_INSERT, OP_APPEND: begin
                     if (count >= CW'(CAPACITY)) begin
                        rsp_ff <= status_rsp(ST_FULL, 1'b0);
                        state_ff <= S_RESP;
                     end else if (req_ff.op == OP_INSERT && req_ff.index > count) begin
                        rsp_ff <= status_rsp(ST_BAD_INDEX, 1'b0);
                        state_ff <= S_RESP;
                     end else begin
                        rsp_ff <= status_rsp(ST_DONE, 1'b0);
                        i_ff <= (req_ff.op == OP_INSERT) ? req_ff.index : count;
                        k_ff <= count;
                        state_ff <= S_SHIFT_RD;
                     end
                  end
                  OP_READ, OP_READ_LAST: begin
                     if (count == '0) begin
                        rsp_ff <= status_rsp(ST_EMPTY, 1'b0);
                        state_ff <= S_RESP;
                     end else if (req_ff.op == OP_READ && req_ff.index >= count) begin
                        rsp_ff <= status_rsp(ST_BAD_INDEX, 1'b0);
                        state_ff <= S_RESP;
                     end else begin
                        rsp_ff <= status_rsp(ST_DONE, 1'b0);
                        i_ff <= (req_ff.op == OP_READ) ? req_ff.index : count - CW'(1);
                        state_ff <= S_READ;
                     end
                  end
                  OP_SWAP: begin
                     if (count == '0) begin
                        rsp_ff <= status_rsp(ST_EMPTY, 1'b0);
                        state_ff <= S_RESP;
                     end else if (req_ff.index == CW'(req_ff.other_index) ||
                           req_ff.index >= count || CW'(req_ff.other_index) >= count) begin
                        rsp_ff <= status_rsp(ST_BAD_INDEX, 1'b0);
                        state_ff <= S_RESP;
                     end else begin
                        rsp_ff <= status_rsp(ST_DONE, 1'b0);
                        i_ff <= req_ff.index;
                        k_ff <= CW'(req_ff.other_index);
                        state_ff <= S_READ;
                     end
                  end
                  OP_SORT: begin
                     rsp_ff <= status_rsp(ST_DONE, 1'b0);
                     i_ff <= CW'(1);
                     state_ff <= (count > CW'(1)) ? S_SORT_KEY : S_RESP;
                  end
                  OP_CHECK: begin
                     rsp_ff <= status_rsp(ST_DONE, 1'b1);
                     i_ff <= CW'(1);
                     state_ff <= (count > CW'(1)) ? S_CHK_RD : S_RESP;
                  end
                  default: begin
                     rsp_ff <= status_rsp(ST_DONE, 1'b0);
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_SHIFT_RD: begin
               if (k_ff == i_ff) begin
                  state_ff <= S_INS_WR;
               end else begin
                  state_ff <= S_SHIFT_WR;
               end
            end
            S_SHIFT_WR: begin
               k_ff <= k_ff - CW'(1);
               state_ff <= S_SHIFT_RD;
            end
            S_INS_WR: state_ff <= S_RESP;
            S_READ: begin
               state_ff <= (req_ff.op == OP_SWAP) ? S_SWAP_RB : S_READ_DONE;
            end
            S_READ_DONE: begin
               rsp_ff.read_value <= rd_a;
               state_ff <= S_RESP;
            end
            S_SWAP_RB: state_ff <= S_SWAP_WA;
            S_SWAP_WA: state_ff <= S_SWAP_WB;
            S_SWAP_WB: state_ff <= S_RESP;
            S_SORT_KEY: begin
               k_ff <= i_ff;
               state_ff <= S_SORT_RD;
            end
            S_SORT_RD: begin
               if (k_ff == i_ff) key_ff <= rd_a;
               state_ff <= S_SORT_CMP;
            end
            S_SORT_CMP: begin
               if (k_ff != '0 && ooo) begin
                  k_ff <= k_ff - CW'(1);
                  state_ff <= (k_ff == CW'(1)) ? S_SORT_CMP : S_SORT_RD;
               end else if (i_ff + CW'(1) >= count) begin
                  state_ff <= S_RESP;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_SORT_KEY;
               end
            end
            S_CHK_RD: state_ff <= S_CHK_CMP;
            S_CHK_CMP: state_ff <= S_CHK_EVAL;
            S_CHK_EVAL: begin
               if (req_ff.descending ? (rd_b < rd_a) : (rd_a < rd_b)) begin
                  rsp_ff.is_sorted <= 1'b0;
                  state_ff <= S_RESP;
               end else if (i_ff + CW'(1) >= count) begin
                  state_ff <= S_RESP;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_CHK_RD;
               end
            end
            S_RESP: begin
               rsp_ff.entry_count <= (cmd_c.kind == CMD_INC_COUNT) ? count + CW'(1) : count;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== sv/ordered_array_table_engine.sv =====
// Top level of the ordered array table engine.
// The block holds up to CAPACITY signed 32-bit entries and a count.
// req_ carries one operation beat (op, index, other_index, value,
// descending); rsp_ returns one beat per request with status, read_value,
// is_sorted and entry_count. Both are valid/ready channels.
// One request is processed at a time: inserts shift entries up one by
// one, the sorted check compares neighbouring entries, and sort runs an
// insertion sort, all paced by the single-port entry memory.
// A new request is taken once the previous response beat has been taken,
// so a stalled receiver holds the block with the response steady.
// Reset clears the count and the control state; entry contents are not
// cleared and only written positions are ever read.
module ordered_array_table_engine (
   input logic clock,
   input logic reset,
   oate_if.sink req,
   oate_if.source rsp
);
   import oate_pkg::*;

   req_type cur_req;
   cmd_type cmd;
   logic [AW-1:0] cmd_addr;
   logic signed [DATA_WIDTH-1:0] rd_a;
   logic signed [DATA_WIDTH-1:0] rd_b;
   logic [COUNT_WIDTH-1:0] count;

   oate_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .req(cur_req), .cmd(cmd), .cmd_addr(cmd_addr),
      .rd_a(rd_a), .rd_b(rd_b), .count(count)
   );

   oate_datapath u_dp (
      .clock(clock), .reset(reset), .req(cur_req), .cmd(cmd),
      .cmd_addr(cmd_addr), .rd_a(rd_a), .rd_b(rd_b), .count(count)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count <= COUNT_WIDTH'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while response pending");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count != $past(count) |-> count == $past(count) + COUNT_WIDTH'(1))
      else $error("count changed by more than one");
endmodule
